// ===== rtl/hangul_syllable_composer_defines.svh =====
// assertion helpers for hangul_syllable_composer.sv
`ifndef HANGUL_SYLLABLE_COMPOSER_DEFINES_SVH
`define HANGUL_SYLLABLE_COMPOSER_DEFINES_SVH

// same-cycle implication
`define HSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hsc_pkg;

  // request types
  localparam logic REQ_JAMO  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // composer states
  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_VOWEL = 3'd1;
  localparam logic [2:0] ST_CONS  = 3'd2;
  localparam logic [2:0] ST_IM    = 3'd3;
  localparam logic [2:0] ST_IMF   = 3'd4;
  localparam logic [2:0] ST_IMFF  = 3'd5;

  // character view kinds
  localparam logic [1:0] VIEW_NONE = 2'd0;
  localparam logic [1:0] VIEW_JAMO = 2'd1;
  localparam logic [1:0] VIEW_SYL  = 2'd2;

  localparam logic [6:0] FIRST_VOWEL = 7'd19;
  localparam logic [6:0] KEY_LIMIT   = 7'd40;
  localparam logic [6:0] FIN_NONE    = 7'd40;
  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [15:0] SYL_SKEW   = 16'd572;
  localparam logic [15:0] INI_STRIDE = 16'd588;
  localparam logic [15:0] MED_STRIDE = 16'd28;
  localparam logic [15:0] JAMO_BASE  = 16'h3100;
  localparam logic [15:0] VOWEL_BASE = 16'h314F;

  typedef struct packed {
    logic       req_type;
    logic [5:0] key_index;
  } in_t;

  typedef struct packed {
    logic        commit_valid;
    logic [15:0] commit_code;
    logic        preedit_valid;
    logic [15:0] preedit_code;
  } out_t;

  typedef struct packed {
    logic [2:0] cs;
    logic [6:0] ini;
    logic [6:0] med;
    logic [6:0] fin;
    logic [6:0] cfirst;
    logic [6:0] csecond;
  } comp_t;

  // what to render: a lone jamo (key in ini) or a syllable
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ini;
    logic [6:0] med;
    logic [6:0] fin;
  } view_t;

  function automatic view_t preedit_view(input comp_t st);
    view_t v;
    v.kind = VIEW_NONE;
    v.ini  = st.ini;
    v.med  = st.med;
    v.fin  = st.fin;
    case (st.cs)
      ST_VOWEL: begin
        v.kind = VIEW_JAMO;
        v.ini  = st.med;
      end
      ST_CONS: v.kind = VIEW_JAMO;
      ST_IM: begin
        v.kind = VIEW_SYL;
        v.fin  = FIN_NONE;
      end
      ST_IMF, ST_IMFF: v.kind = VIEW_SYL;
      default: v.kind = VIEW_NONE;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hangul_syllable_composer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// hangul syllable composer
// in channel: in_valid / in_stall / in_data, one beat per key or flush request
//   (req_type 0 = jamo key index, 1 = flush the character under composition)
// out channel: out_valid / out_stall / out_data, exactly one beat per input beat,
//   carrying the committed character (if any) and the current preedit character
// a beat moves when valid is high and stall is low
// an input beat is first taken into the input register, then its result is loaded into the result register
// throughput: one beat per cycle while out_stall is low; the automaton state updates in the same cycle
//   as its result is loaded, so the next key sees it without a gap
// the critical path is the state update feeding the syllable code multiplies
// stall: while out_stall holds a result, one more key is parked in the input
//   register and in_stall rises only when that register is also occupied
// reset (rst_n low, synchronous): no pending character, both registers empty
module hangul_syllable_composer (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire hsc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output hsc_pkg::out_t      out_data
);

  `include "hangul_syllable_composer_defines.svh"

  // input register
  hsc_pkg::in_t   in_r;
  logic           s1_vld_r;

  // automaton state
  hsc_pkg::comp_t state_r;
  hsc_pkg::comp_t state_nxt;

  // result register
  hsc_pkg::out_t  out_data_r;
  hsc_pkg::out_t  out_data_nxt;
  logic           out_vld_r;

  hsc_pkg::view_t commit_view;
  hsc_pkg::view_t pre_view;

  // rendered characters for the result beat
  logic        commit_vld;
  logic [15:0] commit_code;
  logic        pre_vld;
  logic [15:0] pre_code;

  logic out_free;
  logic advance;
  logic in_take;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || !out_stall;
  assign advance  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  hsc_step u_step (
    .st          (state_r),
    .req         (in_r),
    .st_nxt      (state_nxt),
    .commit_view (commit_view)
  );

  // preedit follows the state after this key
  assign pre_view = hsc_pkg::preedit_view(state_nxt);

  hsc_code u_commit_code (
    .view  (commit_view),
    .valid (commit_vld),
    .code  (commit_code)
  );

  hsc_code u_preedit_code (
    .view  (pre_view),
    .valid (pre_vld),
    .code  (pre_code)
  );

  assign out_data_nxt = {commit_vld, commit_code, pre_vld, pre_code};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // input backpressure only when both registers are blocked
  `HSC_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_vld_r && out_stall,
    "in_stall without a blocked result")
  // a parked key is not dropped while the output is stalled
  `HSC_ASSERT_NEXT(a_park_hold, clk, rst_n, in_stall, s1_vld_r,
    "parked key lost")
  // flush leaves nothing pending
  `HSC_ASSERT_NEXT(a_flush_clear, clk, rst_n,
    advance && in_r.req_type == hsc_pkg::REQ_FLUSH,
    state_r.cs == hsc_pkg::ST_START && !out_data_r.preedit_valid,
    "flush left state pending")
  // preedit flag tracks the stored state
  `HSC_ASSERT_NEXT(a_preedit_state, clk, rst_n, advance,
    out_data_r.preedit_valid == (state_r.cs != hsc_pkg::ST_START),
    "preedit flag disagrees with state")

endmodule
`default_nettype wire

// ===== rtl/hsc_code.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hsc_code (
  input  wire hsc_pkg::view_t view,
  output logic                valid,
  output logic [15:0]         code
);

  // low byte of the compatibility jamo for each consonant key
  function automatic logic [7:0] cons_jamo(input logic [6:0] k);
    logic [7:0] r;
    unique case (k)
      7'd0:  r = 8'h31;
      7'd1:  r = 8'h32;
      7'd2:  r = 8'h34;
      7'd3:  r = 8'h37;
      7'd4:  r = 8'h38;
      7'd5:  r = 8'h39;
      7'd6:  r = 8'h41;
      7'd7:  r = 8'h42;
      7'd8:  r = 8'h43;
      7'd9:  r = 8'h45;
      7'd10: r = 8'h46;
      7'd11: r = 8'h47;
      7'd12: r = 8'h48;
      7'd13: r = 8'h49;
      7'd14: r = 8'h4A;
      7'd15: r = 8'h4B;
      7'd16: r = 8'h4C;
      7'd17: r = 8'h4D;
      7'd18: r = 8'h4E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [15:0] jamo_code;
  logic [15:0] syl_code;
  logic [15:0] ini_part;
  logic [15:0] med_part;
  logic [4:0]  vowel_ofs;

  assign vowel_ofs = 5'(view.ini - hsc_pkg::FIRST_VOWEL);
  assign jamo_code = (view.ini < hsc_pkg::FIRST_VOWEL)
                   ? hsc_pkg::JAMO_BASE + {8'd0, cons_jamo(view.ini)}
                   : hsc_pkg::VOWEL_BASE + {11'd0, vowel_ofs};

  assign ini_part = 16'({9'd0, view.ini} * hsc_pkg::INI_STRIDE);
  assign med_part = 16'({9'd0, view.med} * hsc_pkg::MED_STRIDE);
  assign syl_code = hsc_pkg::SYL_BASE - hsc_pkg::SYL_SKEW + {9'd0, view.fin}
                  + ini_part + med_part;

  always_comb begin
    unique case (view.kind)
      hsc_pkg::VIEW_JAMO: begin
        valid = 1'b1;
        code  = jamo_code;
      end
      hsc_pkg::VIEW_SYL: begin
        valid = 1'b1;
        code  = syl_code;
      end
      default: begin
        valid = 1'b0;
        code  = 16'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/hsc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hsc_step (
  input  wire hsc_pkg::comp_t st,
  input  wire hsc_pkg::in_t   req,
  output hsc_pkg::comp_t      st_nxt,
  output hsc_pkg::view_t      commit_view
);

  // final code for a consonant key, zero when it cannot close a syllable
  function automatic logic [6:0] key_final(input logic [6:0] k);
    logic [6:0] r;
    unique case (k)
      7'd0:  r = 7'd41;
      7'd1:  r = 7'd42;
      7'd2:  r = 7'd44;
      7'd3:  r = 7'd47;
      7'd5:  r = 7'd48;
      7'd6:  r = 7'd56;
      7'd7:  r = 7'd57;
      7'd9:  r = 7'd59;
      7'd10: r = 7'd60;
      7'd11: r = 7'd61;
      7'd12: r = 7'd62;
      7'd14: r = 7'd63;
      7'd15: r = 7'd64;
      7'd16: r = 7'd65;
      7'd17: r = 7'd66;
      7'd18: r = 7'd67;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] final_to_initial(input logic [6:0] f);
    logic [6:0] r;
    unique case (f)
      7'd41: r = 7'd0;
      7'd42: r = 7'd1;
      7'd44: r = 7'd2;
      7'd47: r = 7'd3;
      7'd48: r = 7'd5;
      7'd56: r = 7'd6;
      7'd57: r = 7'd7;
      7'd59: r = 7'd9;
      7'd60: r = 7'd10;
      7'd61: r = 7'd11;
      7'd62: r = 7'd12;
      7'd63: r = 7'd14;
      7'd64: r = 7'd15;
      7'd65: r = 7'd16;
      7'd66: r = 7'd17;
      7'd67: r = 7'd18;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] mix_vowel(input logic [6:0] a, input logic [6:0] b);
    logic [6:0] r;
    r = 7'd0;
    if (a == 7'd27 && b == 7'd19) r = 7'd28;
    if (a == 7'd27 && b == 7'd20) r = 7'd29;
    if (a == 7'd27 && b == 7'd39) r = 7'd30;
    if (a == 7'd32 && b == 7'd23) r = 7'd33;
    if (a == 7'd32 && b == 7'd24) r = 7'd34;
    if (a == 7'd32 && b == 7'd39) r = 7'd35;
    if (a == 7'd37 && b == 7'd39) r = 7'd38;
    return r;
  endfunction

  function automatic logic [6:0] mix_final(input logic [6:0] a, input logic [6:0] b);
    logic [6:0] r;
    r = 7'd0;
    if (a == 7'd41 && b == 7'd59) r = 7'd43;
    if (a == 7'd44 && b == 7'd62) r = 7'd45;
    if (a == 7'd44 && b == 7'd67) r = 7'd46;
    if (a == 7'd48 && b == 7'd41) r = 7'd49;
    if (a == 7'd48 && b == 7'd56) r = 7'd50;
    if (a == 7'd48 && b == 7'd57) r = 7'd51;
    if (a == 7'd48 && b == 7'd59) r = 7'd52;
    if (a == 7'd48 && b == 7'd65) r = 7'd53;
    if (a == 7'd48 && b == 7'd66) r = 7'd54;
    if (a == 7'd48 && b == 7'd67) r = 7'd55;
    if (a == 7'd57 && b == 7'd59) r = 7'd58;
    return r;
  endfunction

  logic [6:0] k;
  logic       vowel;
  logic [6:0] mv;
  logic [6:0] kf;
  logic [6:0] mf;

  assign k     = {1'b0, req.key_index};
  assign vowel = (k >= hsc_pkg::FIRST_VOWEL);
  assign mv    = mix_vowel(st.med, k);
  assign kf    = key_final(k);
  assign mf    = (kf != 7'd0 && st.cs == hsc_pkg::ST_IMF) ? mix_final(st.fin, kf) : 7'd0;

  always_comb begin
    st_nxt           = st;
    commit_view.kind = hsc_pkg::VIEW_NONE;
    commit_view.ini  = st.ini;
    commit_view.med  = st.med;
    commit_view.fin  = st.fin;
    if (req.req_type == hsc_pkg::REQ_FLUSH) begin
      commit_view = hsc_pkg::preedit_view(st);
      st_nxt      = '0;
    end else if (k < hsc_pkg::KEY_LIMIT) begin
      case (st.cs)
        hsc_pkg::ST_VOWEL: begin
          if (vowel && mv != 7'd0) begin
            st_nxt.med = mv;
          end else begin
            commit_view.kind = hsc_pkg::VIEW_JAMO;
            commit_view.ini  = st.med;
            if (vowel) begin
              st_nxt.med = k;
            end else begin
              st_nxt.ini = k;
              st_nxt.cs  = hsc_pkg::ST_CONS;
            end
          end
        end
        hsc_pkg::ST_CONS: begin
          if (vowel) begin
            st_nxt.med = k;
            st_nxt.cs  = hsc_pkg::ST_IM;
          end else begin
            commit_view.kind = hsc_pkg::VIEW_JAMO;
            st_nxt.ini       = k;
          end
        end
        hsc_pkg::ST_IM: begin
          if (vowel) begin
            if (mv != 7'd0) begin
              st_nxt.med = mv;
            end else begin
              commit_view.kind = hsc_pkg::VIEW_SYL;
              commit_view.fin  = hsc_pkg::FIN_NONE;
              st_nxt.med       = k;
              st_nxt.cs        = hsc_pkg::ST_VOWEL;
            end
          end else if (kf != 7'd0) begin
            st_nxt.fin = kf;
            st_nxt.cs  = hsc_pkg::ST_IMF;
          end else begin
            commit_view.kind = hsc_pkg::VIEW_SYL;
            commit_view.fin  = hsc_pkg::FIN_NONE;
            st_nxt.ini       = k;
            st_nxt.cs        = hsc_pkg::ST_CONS;
          end
        end
        hsc_pkg::ST_IMF, hsc_pkg::ST_IMFF: begin
          if (vowel) begin
            // the trailing consonant moves over as the next initial
            commit_view.kind = hsc_pkg::VIEW_SYL;
            if (st.cs == hsc_pkg::ST_IMFF) begin
              commit_view.fin = st.cfirst;
              st_nxt.ini      = final_to_initial(st.csecond);
            end else begin
              commit_view.fin = hsc_pkg::FIN_NONE;
              st_nxt.ini      = final_to_initial(st.fin);
            end
            st_nxt.med = k;
            st_nxt.cs  = hsc_pkg::ST_IM;
          end else if (mf != 7'd0) begin
            st_nxt.cfirst  = st.fin;
            st_nxt.csecond = kf;
            st_nxt.fin     = mf;
            st_nxt.cs      = hsc_pkg::ST_IMFF;
          end else begin
            commit_view.kind = hsc_pkg::VIEW_SYL;
            st_nxt.ini       = k;
            st_nxt.cs        = hsc_pkg::ST_CONS;
          end
        end
        default: begin
          if (vowel) begin
            st_nxt.med = k;
            st_nxt.cs  = hsc_pkg::ST_VOWEL;
          end else begin
            st_nxt.ini = k;
            st_nxt.cs  = hsc_pkg::ST_CONS;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
